>>> src/qbvg_pkg.sv
// qbvg_pkg: shared types, codes and helpers for the quad batch vertex generator
// no dependencies; used by every module of the block

package qbvg_pkg;

    // input command codes
    typedef enum logic [1:0] {
        CMD_START    = 2'd0,
        CMD_QUAD     = 2'd1,
        CMD_TEX_QUAD = 2'd2,
        CMD_END      = 2'd3
    } t_cmd;

    // result kinds
    typedef enum logic [1:0] {
        KIND_VERTEX = 2'd0,
        KIND_BIND   = 2'd1,
        KIND_DRAW   = 2'd2
    } t_kind;

    typedef enum logic {
        JOB_QUAD  = 1'b0,
        JOB_FLUSH = 1'b1
    } t_job_kind;

    typedef enum logic [2:0] {
        F_IDLE,
        F_DECIDE,
        F_MATCH,
        F_RESOLVE,
        F_ALLOC,
        F_QUAD
    } t_front_state;

    // job fields sized for the largest slot count and quad budget supported
    localparam int JOB_CNT_W    = 7;
    localparam int JOB_TOT_W    = 19;
    localparam int QUEUE_DEPTH  = 2;
    localparam int PEND_W       = $clog2(QUEUE_DEPTH + 2);
    localparam int IDX_PER_QUAD = 6;

    localparam logic [1:0] LAST_CORNER = 2'd3;

    typedef struct packed {
        logic signed [31:0] m_r0c0;
        logic signed [31:0] m_r0c1;
        logic signed [31:0] m_r0c3;
        logic signed [31:0] m_r1c0;
        logic signed [31:0] m_r1c1;
        logic signed [31:0] m_r1c3;
        logic signed [31:0] m_r2c0;
        logic signed [31:0] m_r2c1;
        logic signed [31:0] m_r2c3;
        logic [31:0]        rgba;
    } t_geom;

    // cnt is the slot for a quad, the number of used slots for a flush
    typedef struct packed {
        t_job_kind              kind;
        logic                   last;
        logic [JOB_CNT_W-1:0]   cnt;
        logic [JOB_TOT_W-1:0]   total;
        t_geom                  geom;
    } t_job;

    typedef struct packed {
        logic                   flush_done;
        logic [JOB_CNT_W-1:0]   rd_idx;
    } t_back_status;

    // floor((+-c0 +-c1) / 2) + c3, wrapped to 32 bits
    function automatic logic signed [31:0] corner_coord(
        input logic               sx_pos,
        input logic               sy_pos,
        input logic signed [31:0] c0,
        input logic signed [31:0] c1,
        input logic signed [31:0] c3
    );
        logic signed [33:0] a;
        logic signed [33:0] b;
        logic signed [33:0] v;
        a = sx_pos ? 34'(c0) : -34'(c0);
        b = sy_pos ? 34'(c1) : -34'(c1);
        v = a + b;
        corner_coord = 32'(v >>> 1) + c3;
    endfunction

endpackage

>>> src/qbvg_queue.sv
// qbvg_queue: two-entry job queue between the front and back parts
// depends on qbvg_pkg for the job type

module qbvg_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  qbvg_pkg::t_job  i_job,
    output logic            o_full,
    output logic            o_valid,
    output qbvg_pkg::t_job  o_job,
    input  logic            i_pop
);

    localparam int PW = $clog2(qbvg_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(qbvg_pkg::QUEUE_DEPTH + 1);

    qbvg_pkg::t_job r_entry [qbvg_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_count == CW'(qbvg_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_entry[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(qbvg_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(qbvg_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_job;
        end
    end

endmodule

>>> src/qbvg_front.sv
// qbvg_front: accepts commands, keeps batch and slot table state, issues jobs
// depends on qbvg_pkg; feeds qbvg_queue and serves table reads for qbvg_back

module qbvg_front #(
    parameter int QUAD_BUDGET = 16384,
    parameter int SLOT_COUNT  = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_cmd,
    input  qbvg_pkg::t_geom             i_geom,
    input  logic [15:0]                 i_tex_handle,
    input  logic [15:0]                 i_white_handle,
    output logic                        o_push,
    output qbvg_pkg::t_job              o_job,
    input  logic                        i_q_full,
    input  qbvg_pkg::t_back_status      i_status,
    output logic [15:0]                 o_rd_data
);

    localparam int SW    = $clog2(SLOT_COUNT);
    localparam int SUW   = $clog2(SLOT_COUNT + 1);
    localparam int LIMIT = QUAD_BUDGET * qbvg_pkg::IDX_PER_QUAD;
    localparam int BIW   = $clog2(LIMIT + 1);

    qbvg_pkg::t_front_state r_state;
    qbvg_pkg::t_front_state n_state;

    qbvg_pkg::t_cmd           r_cmd;
    qbvg_pkg::t_geom          r_geom;
    logic [15:0]              r_handle;
    logic [SW-1:0]            r_slot;
    logic [SLOT_COUNT-1:0]    r_hit;
    logic [15:0]              r_table [SLOT_COUNT];
    logic [SUW-1:0]           r_slots_used;
    logic [BIW-1:0]           r_batch;
    logic [qbvg_pkg::PEND_W-1:0] r_flush_pend;

    logic                  batch_zero;
    logic                  over;
    logic                  tbl_full;
    logic                  found;
    logic [SW-1:0]         hit_slot;
    logic [SLOT_COUNT-1:0] hit;
    logic                  want_flush;
    logic                  flush_last;
    logic                  want_quad;
    logic                  do_start;
    logic                  do_alloc;
    logic                  flush_pushed;
    logic [SW-1:0]         rd_idx;

    assign batch_zero = (r_batch == '0);
    assign over       = (r_batch >= BIW'(LIMIT));
    assign tbl_full   = (r_slots_used >= SUW'(SLOT_COUNT));
    assign found      = |r_hit;
    assign o_stall    = (r_state != qbvg_pkg::F_IDLE);

    // compare the handle against every live slot, entry zero is the white texture
    always_comb begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            hit[i] = (SUW'(i) < r_slots_used) &&
                     (((i == 0) ? i_white_handle : r_table[i]) == r_handle);
        end
    end

    // lowest matching slot wins
    always_comb begin
        hit_slot = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (r_hit[i]) begin
                hit_slot = SW'(i);
            end
        end
    end

    assign rd_idx    = i_status.rd_idx[SW-1:0];
    assign o_rd_data = (rd_idx == '0) ? i_white_handle : r_table[rd_idx];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            qbvg_pkg::F_IDLE: begin
                if (i_valid) begin
                    n_state = qbvg_pkg::F_DECIDE;
                end
            end
            qbvg_pkg::F_DECIDE: begin
                unique case (r_cmd) inside
                    qbvg_pkg::CMD_START: begin
                        n_state = qbvg_pkg::F_IDLE;
                    end
                    qbvg_pkg::CMD_END: begin
                        if (batch_zero || !i_q_full) begin
                            n_state = qbvg_pkg::F_IDLE;
                        end
                    end
                    qbvg_pkg::CMD_QUAD, qbvg_pkg::CMD_TEX_QUAD: begin
                        if (!over || !i_q_full) begin
                            n_state = (r_cmd == qbvg_pkg::CMD_TEX_QUAD) ?
                                      qbvg_pkg::F_MATCH : qbvg_pkg::F_QUAD;
                        end
                    end
                    default: n_state = qbvg_pkg::F_IDLE;
                endcase
            end
            qbvg_pkg::F_MATCH: begin
                n_state = qbvg_pkg::F_RESOLVE;
            end
            qbvg_pkg::F_RESOLVE: begin
                if (found) begin
                    n_state = qbvg_pkg::F_QUAD;
                end else if (!tbl_full || batch_zero || !i_q_full) begin
                    n_state = qbvg_pkg::F_ALLOC;
                end
            end
            qbvg_pkg::F_ALLOC: begin
                if (r_flush_pend == '0) begin
                    n_state = qbvg_pkg::F_QUAD;
                end
            end
            qbvg_pkg::F_QUAD: begin
                if (!i_q_full) begin
                    n_state = qbvg_pkg::F_IDLE;
                end
            end
            default: n_state = qbvg_pkg::F_IDLE;
        endcase
    end

    // outputs and state updates
    always_comb begin
        want_flush = 1'b0;
        flush_last = 1'b0;
        want_quad  = 1'b0;
        do_start   = 1'b0;
        do_alloc   = 1'b0;
        unique case (r_state)
            qbvg_pkg::F_DECIDE: begin
                unique case (r_cmd)
                    qbvg_pkg::CMD_START: begin
                        do_start = 1'b1;
                    end
                    qbvg_pkg::CMD_END: begin
                        want_flush = !batch_zero;
                        flush_last = 1'b1;
                    end
                    default: begin
                        // quad budget spent: flush and restart before the quad
                        want_flush = over;
                        do_start   = over && !i_q_full;
                    end
                endcase
            end
            qbvg_pkg::F_RESOLVE: begin
                if (!found && tbl_full) begin
                    want_flush = !batch_zero;
                    do_start   = batch_zero || !i_q_full;
                end
            end
            qbvg_pkg::F_ALLOC: begin
                // wait until no queued flush still has to read the table
                do_alloc = (r_flush_pend == '0);
            end
            qbvg_pkg::F_QUAD: begin
                want_quad = 1'b1;
            end
            default: begin
                want_quad = 1'b0;
            end
        endcase
    end

    assign o_push       = (want_flush || want_quad) && !i_q_full;
    assign flush_pushed = want_flush && !i_q_full;

    always_comb begin
        o_job.geom = r_geom;
        if (want_flush) begin
            o_job.kind  = qbvg_pkg::JOB_FLUSH;
            o_job.last  = flush_last;
            o_job.cnt   = qbvg_pkg::JOB_CNT_W'(r_slots_used);
            o_job.total = qbvg_pkg::JOB_TOT_W'(r_batch);
        end else begin
            o_job.kind  = qbvg_pkg::JOB_QUAD;
            o_job.last  = 1'b1;
            o_job.cnt   = qbvg_pkg::JOB_CNT_W'(r_slot);
            o_job.total = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= qbvg_pkg::F_IDLE;
            r_slots_used <= SUW'(1);
            r_batch      <= '0;
            r_flush_pend <= '0;
        end else begin
            r_state <= n_state;
            if (do_start) begin
                r_slots_used <= SUW'(1);
                r_batch      <= '0;
            end else if (do_alloc) begin
                r_slots_used <= r_slots_used + 1'b1;
            end else if (want_quad && !i_q_full) begin
                r_batch <= r_batch + BIW'(qbvg_pkg::IDX_PER_QUAD);
            end
            if (flush_pushed && !i_status.flush_done) begin
                r_flush_pend <= r_flush_pend + 1'b1;
            end else if (!flush_pushed && i_status.flush_done) begin
                r_flush_pend <= r_flush_pend - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == qbvg_pkg::F_IDLE && i_valid) begin
            r_cmd    <= qbvg_pkg::t_cmd'(i_cmd);
            r_geom   <= i_geom;
            r_handle <= i_tex_handle;
            r_slot   <= '0;
        end
        if (r_state == qbvg_pkg::F_MATCH) begin
            r_hit <= hit;
        end
        if (r_state == qbvg_pkg::F_RESOLVE && found) begin
            r_slot <= hit_slot;
        end
        if (do_alloc) begin
            r_table[r_slots_used[SW-1:0]] <= r_handle;
            r_slot                        <= r_slots_used[SW-1:0];
        end
    end

endmodule

>>> src/qbvg_back.sv
// qbvg_back: turns queued jobs into vertex, bind and draw results, one per cycle unless the result channel stalls
// depends on qbvg_pkg; reads bound handles through the front's table port

module qbvg_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  qbvg_pkg::t_job              i_job,
    output logic                        o_pop,
    output qbvg_pkg::t_back_status      o_status,
    input  logic [15:0]                 i_rd_data,
    output logic                        o_valid,
    input  logic                        i_stall,
    output qbvg_pkg::t_kind             o_kind,
    output logic signed [31:0]          o_pos_x,
    output logic signed [31:0]          o_pos_y,
    output logic signed [31:0]          o_pos_z,
    output logic [31:0]                 o_vert_color,
    output logic [1:0]                  o_corner,
    output logic [4:0]                  o_slot,
    output logic [15:0]                 o_bound_handle,
    output logic [16:0]                 o_index_total,
    output logic                        o_last
);

    logic                               r_busy;
    qbvg_pkg::t_job                     r_job;
    logic [qbvg_pkg::JOB_CNT_W-1:0]     r_idx;
    logic                               r_out_valid;

    logic       room;
    logic       adv;
    logic       done;
    logic [1:0] k;
    logic       sx_pos;
    logic       sy_pos;
    logic       is_bind;

    assign room    = !r_out_valid || !i_stall;
    assign adv     = r_busy && room;
    assign k       = r_idx[1:0];
    assign sx_pos  = k[0] ^ k[1];
    assign sy_pos  = k[1];
    assign is_bind = (r_idx < r_job.cnt);
    assign done    = (r_job.kind == qbvg_pkg::JOB_QUAD) ? (k == qbvg_pkg::LAST_CORNER) : !is_bind;
    assign o_pop   = i_q_valid && (!r_busy || (adv && done));

    assign o_status.flush_done = adv && done && (r_job.kind == qbvg_pkg::JOB_FLUSH);
    assign o_status.rd_idx     = r_idx;
    assign o_valid             = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (adv && done) begin
                r_busy <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
            r_idx <= '0;
        end else if (adv) begin
            r_idx <= r_idx + 1'b1;
        end
        if (adv) begin
            o_pos_x        <= '0;
            o_pos_y        <= '0;
            o_pos_z        <= '0;
            o_vert_color   <= '0;
            o_corner       <= '0;
            o_slot         <= '0;
            o_bound_handle <= '0;
            o_index_total  <= '0;
            o_last         <= r_job.last && done;
            if (r_job.kind == qbvg_pkg::JOB_QUAD) begin
                o_kind       <= qbvg_pkg::KIND_VERTEX;
                o_pos_x      <= qbvg_pkg::corner_coord(sx_pos, sy_pos, r_job.geom.m_r0c0,
                                                       r_job.geom.m_r0c1, r_job.geom.m_r0c3);
                o_pos_y      <= qbvg_pkg::corner_coord(sx_pos, sy_pos, r_job.geom.m_r1c0,
                                                       r_job.geom.m_r1c1, r_job.geom.m_r1c3);
                o_pos_z      <= qbvg_pkg::corner_coord(sx_pos, sy_pos, r_job.geom.m_r2c0,
                                                       r_job.geom.m_r2c1, r_job.geom.m_r2c3);
                o_vert_color <= r_job.geom.rgba;
                o_corner     <= k;
                o_slot       <= r_job.cnt[4:0];
            end else if (is_bind) begin
                o_kind         <= qbvg_pkg::KIND_BIND;
                o_slot         <= r_idx[4:0];
                o_bound_handle <= i_rd_data;
            end else begin
                o_kind        <= qbvg_pkg::KIND_DRAW;
                o_index_total <= r_job.total[16:0];
            end
        end
    end

endmodule

>>> src/quad_batch_vertex_generator_unit.sv
// quad batch vertex generator, top level: config register, front, queue and back
// an untextured quad passes the front's decide and quad states, a textured one also match and
// resolve, and alloc when it takes a new slot; then the queue and the back's output register
// the back emits one result per cycle unless the result channel stalls; a quad gives four
// vertex results and a flush slots_used bind results and a draw
// reset: synchronous, active low; empty batch, one slot used, white handle zero

module quad_batch_vertex_generator_unit #(
    parameter int QUAD_BUDGET = 16384,
    parameter int SLOT_COUNT  = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // command channel
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_cmd,
    input  logic signed [31:0]  i_m_r0c0,
    input  logic signed [31:0]  i_m_r0c1,
    input  logic signed [31:0]  i_m_r0c3,
    input  logic signed [31:0]  i_m_r1c0,
    input  logic signed [31:0]  i_m_r1c1,
    input  logic signed [31:0]  i_m_r1c3,
    input  logic signed [31:0]  i_m_r2c0,
    input  logic signed [31:0]  i_m_r2c1,
    input  logic signed [31:0]  i_m_r2c3,
    input  logic [31:0]         i_rgba,
    input  logic [15:0]         i_tex_handle,
    // result channel
    output logic                o_valid,
    input  logic                i_stall,
    output logic [1:0]          o_kind,
    output logic signed [31:0]  o_pos_x,
    output logic signed [31:0]  o_pos_y,
    output logic signed [31:0]  o_pos_z,
    output logic [31:0]         o_vert_color,
    output logic [1:0]          o_corner,
    output logic [4:0]          o_slot,
    output logic [15:0]         o_bound_handle,
    output logic [16:0]         o_index_total,
    output logic                o_last
);

    localparam logic REG_WHITE = 1'b0;

    logic [15:0]                r_white_handle;
    qbvg_pkg::t_geom            geom;
    logic                       q_push;
    qbvg_pkg::t_job             q_in;
    logic                       q_full;
    logic                       q_valid;
    qbvg_pkg::t_job             q_out;
    logic                       q_pop;
    qbvg_pkg::t_back_status     back_status;
    logic [15:0]                rd_data;
    qbvg_pkg::t_kind            kind;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_WHITE) ? {16'b0, r_white_handle} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_white_handle <= '0;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_WHITE) begin
            r_white_handle <= pwdata[15:0];
        end
    end

    assign geom.m_r0c0 = i_m_r0c0;
    assign geom.m_r0c1 = i_m_r0c1;
    assign geom.m_r0c3 = i_m_r0c3;
    assign geom.m_r1c0 = i_m_r1c0;
    assign geom.m_r1c1 = i_m_r1c1;
    assign geom.m_r1c3 = i_m_r1c3;
    assign geom.m_r2c0 = i_m_r2c0;
    assign geom.m_r2c1 = i_m_r2c1;
    assign geom.m_r2c3 = i_m_r2c3;
    assign geom.rgba   = i_rgba;

    qbvg_front #(
        .QUAD_BUDGET (QUAD_BUDGET),
        .SLOT_COUNT  (SLOT_COUNT)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_cmd          (i_cmd),
        .i_geom         (geom),
        .i_tex_handle   (i_tex_handle),
        .i_white_handle (r_white_handle),
        .o_push         (q_push),
        .o_job          (q_in),
        .i_q_full       (q_full),
        .i_status       (back_status),
        .o_rd_data      (rd_data)
    );

    qbvg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_out),
        .i_pop   (q_pop)
    );

    qbvg_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_job          (q_out),
        .o_pop          (q_pop),
        .o_status       (back_status),
        .i_rd_data      (rd_data),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_kind         (kind),
        .o_pos_x        (o_pos_x),
        .o_pos_y        (o_pos_y),
        .o_pos_z        (o_pos_z),
        .o_vert_color   (o_vert_color),
        .o_corner       (o_corner),
        .o_slot         (o_slot),
        .o_bound_handle (o_bound_handle),
        .o_index_total  (o_index_total),
        .o_last         (o_last)
    );

    assign o_kind = kind;

endmodule

>>> src/qbvg_checker.sv
// qbvg_checker: port-level assertions on the result channel of the generator
// depends on qbvg_pkg; bound to quad_batch_vertex_generator_unit below

module qbvg_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_valid,
    input logic         i_stall,
    input logic [1:0]   o_kind,
    input logic [1:0]   o_corner,
    input logic [15:0]  o_bound_handle,
    input logic [16:0]  o_index_total,
    input logic         o_last
);

    // a stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_corner) &&
                               $stable(o_bound_handle) && $stable(o_index_total) &&
                               $stable(o_last))
        else $error("stalled result beat changed");

    // only the fourth corner of a quad can close an item
    a_last_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == qbvg_pkg::KIND_VERTEX && o_corner != qbvg_pkg::LAST_CORNER
        |-> !o_last)
        else $error("last flag on an inner corner");

    // corners of one quad leave back to back
    a_corner_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_kind == qbvg_pkg::KIND_VERTEX &&
        o_corner != qbvg_pkg::LAST_CORNER
        |=> o_valid && o_kind == qbvg_pkg::KIND_VERTEX &&
            o_corner == $past(o_corner) + 2'd1)
        else $error("quad corners out of sequence");

    // an empty batch never draws
    a_draw_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == qbvg_pkg::KIND_DRAW |-> o_index_total != '0)
        else $error("draw with no indices");

endmodule

bind quad_batch_vertex_generator_unit qbvg_checker u_qbvg_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_kind         (o_kind),
    .o_corner       (o_corner),
    .o_bound_handle (o_bound_handle),
    .o_index_total  (o_index_total),
    .o_last         (o_last)
);
